// ===== rtl/core/rwlm_pkg.sv =====
// Package for the reader-writer lock manager: sizes, operation and status codes,
// and the command and status bundles between the controller and the datapath.
// No dependencies.
package rwlm_pkg;

  localparam int QueueDepth = 16;
  localparam int TidW       = 8;
  localparam int HeadW      = $clog2(QueueDepth);
  localparam int FillW      = $clog2(QueueDepth + 1);
  localparam int OpW        = 3;
  localparam int StatusW    = 3;
  localparam int ReadersW   = 16;
  localparam int WritersW   = 5;

  localparam logic [ReadersW-1:0] ReaderMax = '1;
  localparam logic [WritersW-1:0] WriterMax = '1;

  localparam logic [OpW-1:0] OpAcqRead  = 3'd0;
  localparam logic [OpW-1:0] OpAcqWrite = 3'd1;
  localparam logic [OpW-1:0] OpTryRead  = 3'd2;
  localparam logic [OpW-1:0] OpTryWrite = 3'd3;
  localparam logic [OpW-1:0] OpRelRead  = 3'd4;
  localparam logic [OpW-1:0] OpRelWrite = 3'd5;

  localparam logic [StatusW-1:0] StGranted = 3'd0;
  localparam logic [StatusW-1:0] StQueued  = 3'd1;
  localparam logic [StatusW-1:0] StRefused = 3'd2;
  localparam logic [StatusW-1:0] StWoken   = 3'd3;
  localparam logic [StatusW-1:0] StError   = 3'd4;
  localparam logic [StatusW-1:0] StFull    = 3'd5;

  typedef struct packed {
    logic latch;  // capture the incoming request
    logic exec;   // decide the request, update counts, send its first word
    logic wake;   // pop one waiter and send its wake word
  } cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a word this cycle
    logic exec_wakes;  // the request being decided wakes at least one thread
    logic wake_last;   // exactly one wake remains
  } status_t;

endpackage

// ===== rtl/core/reader_writer_lock_manager_unit.sv =====
// Top level of the reader-writer lock manager: controller plus datapath.
// Depends on rwlm_pkg, rwlm_ctrl and rwlm_datapath.
//
//   Channel | Direction | Handshake              | Word
//   in      | input     | in_valid_i/in_stall_o  | operation_i, thread_id_i
//   out     | output    | out_valid_o/out_stall_i| status_o, thread_id_res_o,
//           |           |                        | readers_now_o, writers_now_o, last_o
//
// A request is captured first and then decided, which loads its first result word into
// the output register. Each woken thread then adds one wake word, sent one at a time
// through the single queue read port; a write release can wake up to 16 readers.
// The next request is taken while the final word still waits in the output register.
// Reset clears the counts and queue pointers; queue entries are not cleared.
// A stalled output holds the word and holds the sequencer until it is taken.
module reader_writer_lock_manager_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rwlm_pkg::OpW-1:0]      operation_i,
  input  logic [rwlm_pkg::TidW-1:0]     thread_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rwlm_pkg::StatusW-1:0]  status_o,
  output logic [rwlm_pkg::TidW-1:0]     thread_id_res_o,
  output logic [rwlm_pkg::ReadersW-1:0] readers_now_o,
  output logic [rwlm_pkg::WritersW-1:0] writers_now_o,
  output logic                          last_o
);
  import rwlm_pkg::*;

  cmd_t    cmd;
  status_t stat;

  rwlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  rwlm_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .operation_i     (operation_i),
    .thread_id_i     (thread_id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .thread_id_res_o (thread_id_res_o),
    .readers_now_o   (readers_now_o),
    .writers_now_o   (writers_now_o),
    .last_o          (last_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

// ===== rtl/core/rwlm_ctrl.sv =====
// Controller of the reader-writer lock manager: request sequencing state machine.
// Depends on rwlm_pkg.
module rwlm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output rwlm_pkg::cmd_t    cmd_o,
  input  rwlm_pkg::status_t stat_i
);
  import rwlm_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SExec = 2'd1;
  localparam logic [1:0] SWake = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o  = (state_q != SIdle);
  assign cmd_o.latch = (state_q == SIdle) && in_valid_i;
  assign cmd_o.exec  = (state_q == SExec) && stat_i.out_free;
  assign cmd_o.wake  = (state_q == SWake) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (in_valid_i) state_d = SExec;
      end
      SExec: begin
        if (stat_i.out_free) state_d = stat_i.exec_wakes ? SWake : SIdle;
      end
      SWake: begin
        if (stat_i.out_free && stat_i.wake_last) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/rwlm_datapath.sv =====
// Datapath of the reader-writer lock manager: counts, the two wait queues,
// the request decision and the output register. Depends on rwlm_pkg.
module rwlm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rwlm_pkg::OpW-1:0]      operation_i,
  input  logic [rwlm_pkg::TidW-1:0]     thread_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rwlm_pkg::StatusW-1:0]  status_o,
  output logic [rwlm_pkg::TidW-1:0]     thread_id_res_o,
  output logic [rwlm_pkg::ReadersW-1:0] readers_now_o,
  output logic [rwlm_pkg::WritersW-1:0] writers_now_o,
  output logic                          last_o,
  input  rwlm_pkg::cmd_t                 cmd_i,
  output rwlm_pkg::status_t              stat_o
);
  import rwlm_pkg::*;

  localparam logic [FillW-1:0] FillFull = FillW'(QueueDepth);
  localparam logic [FillW:0]   DepthX   = (FillW + 1)'(QueueDepth);
  localparam logic [HeadW-1:0] HeadLast = HeadW'(QueueDepth - 1);

  // Request latched at acceptance.
  logic [OpW-1:0]  op_q;
  logic [TidW-1:0] tid_q;

  // Lock state.
  logic [ReadersW-1:0] rc_q;
  logic [WritersW-1:0] wc_q;
  logic [HeadW-1:0]    rhead_q, whead_q;
  logic [FillW-1:0]    rfill_q, wfill_q;
  logic [TidW-1:0]     rids_q [QueueDepth];
  logic [TidW-1:0]     wids_q [QueueDepth];

  // Pending wakes of the current request.
  logic [FillW-1:0] wake_cnt_q;
  logic             wake_w_q;

  // Output register.
  logic                out_valid_q;
  logic [StatusW-1:0]  ost_q;
  logic [TidW-1:0]     otid_q;
  logic [ReadersW-1:0] ord_q;
  logic [WritersW-1:0] owr_q;
  logic                olast_q;

  // Decision of the latched request.
  logic [StatusW-1:0]  st_d;
  logic [ReadersW-1:0] rc_d;
  logic [WritersW-1:0] wc_d;
  logic                push_r, push_w;
  logic [FillW-1:0]    nwake;
  logic                wake_w;

  always_comb begin
    st_d   = StError;
    rc_d   = rc_q;
    wc_d   = wc_q;
    push_r = 1'b0;
    push_w = 1'b0;
    nwake  = '0;
    wake_w = 1'b0;
    case (op_q)
      OpAcqRead: begin
        if (wc_q == '0) begin
          if (rc_q == ReaderMax) begin
            st_d = StRefused;
          end else begin
            rc_d = rc_q + 1'b1;
            st_d = StGranted;
          end
        end else if (rfill_q == FillFull) begin
          st_d = StFull;
        end else begin
          push_r = 1'b1;
          st_d   = StQueued;
        end
      end
      OpAcqWrite: begin
        if (wc_q == '0 && rc_q == '0) begin
          wc_d = WritersW'(1);
          st_d = StGranted;
        end else if (wfill_q == FillFull) begin
          st_d = StFull;
        end else if (wc_q == WriterMax) begin
          st_d = StRefused;
        end else begin
          wc_d   = wc_q + 1'b1;
          push_w = 1'b1;
          st_d   = StQueued;
        end
      end
      OpTryRead: begin
        if (wc_q == '0 && rc_q != ReaderMax) begin
          rc_d = rc_q + 1'b1;
          st_d = StGranted;
        end else begin
          st_d = StRefused;
        end
      end
      OpTryWrite: begin
        if (wc_q == '0 && rc_q == '0) begin
          wc_d = WritersW'(1);
          st_d = StGranted;
        end else begin
          st_d = StRefused;
        end
      end
      OpRelRead: begin
        if (rc_q != '0) begin
          rc_d = rc_q - 1'b1;
          st_d = StGranted;
          // The last reader out hands the lock to the oldest waiting writer.
          if (rc_q == ReadersW'(1) && wc_q != '0 && wfill_q != '0) begin
            nwake  = FillW'(1);
            wake_w = 1'b1;
          end
        end
      end
      OpRelWrite: begin
        if (wc_q != '0 && rc_q == '0) begin
          wc_d = wc_q - 1'b1;
          st_d = StGranted;
          if (wc_q != WritersW'(1)) begin
            if (wfill_q != '0) begin
              nwake  = FillW'(1);
              wake_w = 1'b1;
            end
          end else begin
            // No writer left: every queued reader is woken and counted at once,
            // so all words of this request report the final reader count.
            nwake = rfill_q;
            rc_d  = ReadersW'(rfill_q);
          end
        end
      end
      default: st_d = StError;
    endcase
  end

  // Queue tails and head advance.
  logic [FillW:0]   rtail_sum, wtail_sum;
  logic [HeadW-1:0] rtail, wtail, rhead_nx, whead_nx;

  always_comb begin
    rtail_sum = {1'b0, FillW'(rhead_q)} + {1'b0, rfill_q};
    wtail_sum = {1'b0, FillW'(whead_q)} + {1'b0, wfill_q};
    if (rtail_sum >= DepthX) rtail_sum = rtail_sum - DepthX;
    if (wtail_sum >= DepthX) wtail_sum = wtail_sum - DepthX;
    rtail    = rtail_sum[HeadW-1:0];
    wtail    = wtail_sum[HeadW-1:0];
    rhead_nx = (rhead_q == HeadLast) ? '0 : rhead_q + 1'b1;
    whead_nx = (whead_q == HeadLast) ? '0 : whead_q + 1'b1;
  end

  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign stat_o.exec_wakes = (nwake != '0);
  assign stat_o.wake_last  = (wake_cnt_q == FillW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q        <= '0;
      wc_q        <= '0;
      rhead_q     <= '0;
      rfill_q     <= '0;
      whead_q     <= '0;
      wfill_q     <= '0;
      wake_cnt_q  <= '0;
      wake_w_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec || cmd_i.wake) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        rc_q       <= rc_d;
        wc_q       <= wc_d;
        wake_cnt_q <= nwake;
        wake_w_q   <= wake_w;
        if (push_r) rfill_q <= rfill_q + 1'b1;
        if (push_w) wfill_q <= wfill_q + 1'b1;
      end else if (cmd_i.wake) begin
        wake_cnt_q <= wake_cnt_q - 1'b1;
        if (wake_w_q) begin
          whead_q <= whead_nx;
          wfill_q <= wfill_q - 1'b1;
        end else begin
          rhead_q <= rhead_nx;
          rfill_q <= rfill_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= operation_i;
      tid_q <= thread_id_i;
    end
    if (cmd_i.exec && push_r) rids_q[rtail] <= tid_q;
    if (cmd_i.exec && push_w) wids_q[wtail] <= tid_q;
    if (cmd_i.exec) begin
      ost_q   <= st_d;
      otid_q  <= tid_q;
      ord_q   <= rc_d;
      owr_q   <= wc_d;
      olast_q <= (nwake == '0);
    end else if (cmd_i.wake) begin
      ost_q   <= StWoken;
      otid_q  <= wake_w_q ? wids_q[whead_q] : rids_q[rhead_q];
      ord_q   <= rc_q;
      owr_q   <= wc_q;
      olast_q <= (wake_cnt_q == FillW'(1));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = ost_q;
  assign thread_id_res_o = otid_q;
  assign readers_now_o   = ord_q;
  assign writers_now_o   = owr_q;
  assign last_o          = olast_q;

endmodule

// ===== rtl/core/rwlm_checker.sv =====
// Port-level checks for the reader-writer lock manager, bound to the top level.
// Depends on rwlm_pkg and reader_writer_lock_manager_unit.
module rwlm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rwlm_pkg::StatusW-1:0]  status_o,
  input logic                          last_o
);
  import rwlm_pkg::*;

  // A held output word stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A request is decided before another one is taken.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on back-to-back cycles");

  // A word that is not the last one is followed at once by a wake word.
  a_wake_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && status_o == StWoken)
    else $error("missing wake word after a non-final word");

  // Only a granted or woken word can be followed by wakes; every other status is final.
  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StGranted && status_o != StWoken |-> last_o)
    else $error("refusal or error not marked final");

endmodule

bind reader_writer_lock_manager_unit rwlm_checker u_rwlm_checker (.*);

// ===== tb/reader_writer_lock_manager_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for reader_writer_lock_manager_unit: a lock predictor in a scoreboard
// class checks every result word, with random idling on both channels.
// Depends on rwlm_pkg and the reader_writer_lock_manager_unit RTL.
module reader_writer_lock_manager_unit_tb;
  import rwlm_pkg::*;

  localparam int RandomRequests = 480;
  localparam int QuietLimit     = 2000;
  localparam int DrainCycles    = 64;

  // Operation codes that the block does not define; it must answer them with an error.
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  typedef enum int {ModeGrow, ModeShrink, ModeFloodWrite, ModeFloodRead} traffic_mode_e;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [TidW-1:0]     tid;
    logic [ReadersW-1:0] readers;
    logic [WritersW-1:0] writers;
    logic                last;
  } lock_word_t;

  class lock_scoreboard;
    logic [ReadersW-1:0] readers;
    logic [WritersW-1:0] writers;
    logic [TidW-1:0]     read_waiters[$];
    logic [TidW-1:0]     write_waiters[$];
    lock_word_t          pending[$];
    lock_word_t          staged[$];
    int                  fails;

    function new();
      readers = '0;
      writers = '0;
      fails   = 0;
    endfunction

    function void stage(logic [StatusW-1:0] status, logic [TidW-1:0] tid);
      lock_word_t w;
      w = '0;
      w.status = status;
      w.tid    = tid;
      staged.push_back(w);
    endfunction

    // Advances the lock state by one accepted request and queues the words it should cause.
    function void note_request(logic [OpW-1:0] op, logic [TidW-1:0] tid);
      lock_word_t w;
      case (op)
        OpAcqRead: begin
          if (writers == 0) begin
            if (readers == ReaderMax) stage(StRefused, tid);
            else begin
              readers++;
              stage(StGranted, tid);
            end
          end else if (read_waiters.size() >= QueueDepth) begin
            stage(StFull, tid);
          end else begin
            read_waiters.push_back(tid);
            stage(StQueued, tid);
          end
        end
        OpAcqWrite: begin
          if (writers == 0 && readers == 0) begin
            writers = WritersW'(1);
            stage(StGranted, tid);
          end else if (write_waiters.size() >= QueueDepth) begin
            stage(StFull, tid);
          end else if (writers == WriterMax) begin
            stage(StRefused, tid);
          end else begin
            writers++;
            write_waiters.push_back(tid);
            stage(StQueued, tid);
          end
        end
        OpTryRead: begin
          if (writers == 0 && readers != ReaderMax) begin
            readers++;
            stage(StGranted, tid);
          end else begin
            stage(StRefused, tid);
          end
        end
        OpTryWrite: begin
          if (writers == 0 && readers == 0) begin
            writers = WritersW'(1);
            stage(StGranted, tid);
          end else begin
            stage(StRefused, tid);
          end
        end
        OpRelRead: begin
          if (readers == 0) begin
            stage(StError, tid);
          end else begin
            readers--;
            stage(StGranted, tid);
            // The last reader out hands the lock to the oldest waiting writer.
            if (readers == 0 && writers != 0 && write_waiters.size() != 0)
              stage(StWoken, write_waiters.pop_front());
          end
        end
        OpRelWrite: begin
          if (writers == 0 || readers != 0) begin
            stage(StError, tid);
          end else begin
            writers--;
            stage(StGranted, tid);
            if (writers != 0) begin
              if (write_waiters.size() != 0) stage(StWoken, write_waiters.pop_front());
            end else begin
              // With no writer left, every queued reader is let in at once.
              while (read_waiters.size() != 0 && readers != ReaderMax) begin
                readers++;
                stage(StWoken, read_waiters.pop_front());
              end
            end
          end
        end
        default: stage(StError, tid);
      endcase
      // Every word of a request carries the counts after the whole request.
      foreach (staged[k]) begin
        w = staged[k];
        w.readers = readers;
        w.writers = writers;
        w.last    = (k == staged.size() - 1);
        pending.push_back(w);
      end
      staged.delete();
    endfunction

    task report(string msg);
      fails++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_word(lock_word_t got);
      lock_word_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word: status %0d thread %0d readers %0d writers %0d last %0b",
                         got.status, got.tid, got.readers, got.writers, got.last));
      end else begin
        want = pending.pop_front();
        if (got !== want)
          report($sformatf({"word mismatch: got status %0d thread %0d readers %0d writers %0d ",
                            "last %0b, wanted %0d %0d %0d %0d %0b"},
                           got.status, got.tid, got.readers, got.writers, got.last,
                           want.status, want.tid, want.readers, want.writers, want.last));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [OpW-1:0]      operation_i = '0;
  logic [TidW-1:0]     thread_id_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [TidW-1:0]     thread_id_res_o;
  logic [ReadersW-1:0] readers_now_o;
  logic [WritersW-1:0] writers_now_o;
  logic                last_o;

  lock_scoreboard sb;

  int in_calm_left = 0;
  bit in_calm      = 1'b0;

  reader_writer_lock_manager_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .thread_id_i     (thread_id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .thread_id_res_o (thread_id_res_o),
    .readers_now_o   (readers_now_o),
    .writers_now_o   (writers_now_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one request word after a random gap and returns at the edge that accepts it.
  task automatic send_request(logic [OpW-1:0] op, logic [TidW-1:0] tid);
    int gap;
    if (in_calm_left == 0) begin
      in_calm_left = $urandom_range(8, 40);
      in_calm      = ($urandom_range(0, 2) == 0);
    end
    in_calm_left--;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    thread_id_i <= tid;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, tid);
  endtask

  initial begin : stimulus
    traffic_mode_e   mode;
    int              mode_left;
    int              write_share;
    int              roll;
    bit              rel_write_ok;
    logic [OpW-1:0]  op;
    logic [TidW-1:0] tid;

    sb = new();
    mode = ModeGrow;
    mode_left = 0;
    write_share = 50;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unmatched releases and undefined codes on an idle lock.
    send_request(OpRelRead, 8'h00);
    send_request(OpRelWrite, 8'hff);
    send_request(OpSpare6, 8'haa);
    send_request(OpSpare7, 8'h55);
    // A reader holds: try write is refused, a writer and a reader queue up.
    send_request(OpTryRead, 8'h01);
    send_request(OpTryWrite, 8'h02);
    send_request(OpAcqWrite, 8'h03);
    send_request(OpRelWrite, 8'h04);
    send_request(OpAcqRead, 8'h05);
    send_request(OpTryRead, 8'h06);
    // Last reader out wakes the writer; a release then hands over writer to writer.
    send_request(OpRelRead, 8'h07);
    send_request(OpAcqRead, 8'h08);
    send_request(OpTryWrite, 8'h09);
    send_request(OpAcqWrite, 8'h80);
    send_request(OpRelWrite, 8'h0a);
    // Final writer out wakes both queued readers.
    send_request(OpRelWrite, 8'h0b);
    send_request(OpRelRead, 8'hfe);
    send_request(OpRelRead, 8'h7f);
    send_request(OpTryWrite, 8'hff);
    send_request(OpAcqRead, 8'h00);
    send_request(OpRelWrite, 8'hff);
    send_request(OpRelRead, 8'h01);

    // Stretches of traffic: growing, shrinking, and floods that fill one wait queue.
    for (int n = 0; n < RandomRequests; n++) begin
      if (mode_left == 0) begin
        mode        = traffic_mode_e'($urandom_range(0, 3));
        mode_left   = (mode == ModeFloodWrite || mode == ModeFloodRead) ?
                      $urandom_range(18, 24) : $urandom_range(10, 40);
        write_share = $urandom_range(0, 100);
      end
      mode_left--;
      tid          = TidW'($urandom_range(0, 255));
      roll         = $urandom_range(0, 99);
      rel_write_ok = (sb.writers != 0 && sb.readers == 0);
      if (roll < 6) begin
        op = OpW'($urandom_range(0, 7));
      end else begin
        case (mode)
          ModeGrow: begin
            if (roll < 70)
              op = ($urandom_range(0, 99) < write_share) ? OpAcqWrite : OpAcqRead;
            else if (roll < 85)
              op = ($urandom_range(0, 1) == 1) ? OpTryWrite : OpTryRead;
            else
              op = rel_write_ok ? OpRelWrite : OpRelRead;
          end
          ModeShrink: begin
            if (roll < 80) begin
              if (rel_write_ok) op = OpRelWrite;
              else if (sb.readers != 0) op = OpRelRead;
              else op = OpW'($urandom_range(0, 3));
            end else begin
              op = OpW'($urandom_range(0, 3));
            end
          end
          ModeFloodWrite: begin
            if (roll < 90) op = OpAcqWrite;
            else op = (sb.readers != 0) ? OpRelRead : OpAcqRead;
          end
          default: begin
            // Readers only queue while a writer is counted, so take the lock first.
            op = (sb.writers == 0) ? OpAcqWrite : OpAcqRead;
          end
        endcase
      end
      send_request(op, tid);
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("reader_writer_lock_manager_unit_tb: PASS");
    end else begin
      $display("reader_writer_lock_manager_unit_tb: FAIL");
    end
    $finish;
  end

  // Takes result words with a random stall ahead of each one.
  initial begin : word_sink
    lock_word_t got;
    int         stall_len;
    int         calm_left;
    bit         calm;

    calm_left = 0;
    calm      = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (calm_left == 0) begin
        calm_left = $urandom_range(8, 40);
        calm      = ($urandom_range(0, 2) == 0);
      end
      calm_left--;
      stall_len = calm ? 0 : $urandom_range(0, 19);
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.status  = status_o;
      got.tid     = thread_id_res_o;
      got.readers = readers_now_o;
      got.writers = writers_now_o;
      got.last    = last_o;
      sb.check_word(got);
    end
  end

  // Ends the run once neither channel has moved a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("reader_writer_lock_manager_unit_tb: FAIL");
    $finish;
  end

endmodule
